[rtl/lcmr_pkg.sv]
// ----------------------------------------------------------------------------
// lcmr_pkg
// Shared codes, state and command types of the contour mask renderer.
// ----------------------------------------------------------------------------
package lcmr_pkg;

  // fixed field widths
  localparam int COORD_W  = 9;
  localparam int VALUE_W  = 32;
  localparam int CFG_W    = 31;
  localparam int LINE_W   = 7;
  localparam int RADIUS_W = 20;
  localparam int COUNT_W  = 4;
  localparam int OP_W     = 2;
  localparam int SLOT_W   = 3;
  localparam int CIDX_W   = 2;

  // item op codes
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_EXTREMA = 2'd1;
  localparam logic [OP_W-1:0] OP_CONTOUR = 2'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_LINE_COUNT   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_RADIUS_SQ    = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_FLOOR        = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_CHARGE_COUNT = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_EXT,
    S_LOG_LOAD,
    S_LOG_NORM,
    S_LOG_SQ,
    S_LOG_STORE,
    S_BAND_INIT,
    S_BAND,
    S_EMIT
  } state_t;

  // operand of the shared log unit
  typedef enum logic [1:0] {
    JOB_FLOOR,
    JOB_MAX,
    JOB_MIN,
    JOB_VAL
  } job_t;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic ext_update;
    logic log_load;
    logic log_norm;
    logic log_sq;
    logic log_store;
    job_t job;
    logic band_init;
    logic band_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic first;
    logic scan_done;
    logic norm_done;
    logic sq_last;
    logic band_last;
  } status_t;

endpackage

[rtl/log_contour_mask_render.sv]
// ----------------------------------------------------------------------------
// log_contour_mask_render
// Contour mask of a sampled potential field with log-spaced levels.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Op load stores a
// charge position and gives no result. An extrema sample updates the running
// minimum and maximum; a contour sample decides pixel_on. Each of these two
// gives one result, shown for one cycle with result_valid high; the receiver
// cannot stall it. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user must write it only while busy is low, not checked by the block.
// A load needs no sequencing. An extrema sample scans the used charges,
// one distance check a cycle, then updates the extrema. A contour sample
// scans the charges too, then adds two log evaluations (four on the first
// sample of the pass) in the shared log unit (normalize shifts, then one
// squaring a cycle), and a band search of up to line_count levels, one
// level a cycle.
// Reset clears the controller, the extrema, the level scales and the
// configuration to its defaults; charge positions stay unknown until loaded.
// ----------------------------------------------------------------------------
module log_contour_mask_render #(
  parameter int MAX_CHARGES   = 8,
  parameter int LOG_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [lcmr_pkg::OP_W-1:0]           op,
  input  logic [lcmr_pkg::SLOT_W-1:0]         charge_slot,
  input  logic [lcmr_pkg::COORD_W-1:0]        x_coord,
  input  logic [lcmr_pkg::COORD_W-1:0]        y_coord,
  input  logic signed [lcmr_pkg::VALUE_W-1:0] sample_value,
  input  logic                                first_of_pass,
  input  logic                                cfg_we,
  input  logic [lcmr_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [lcmr_pkg::CFG_W-1:0]          cfg_data,
  output logic                                result_valid,
  output logic                                pixel_on,
  output logic                                near_charge,
  output logic signed [lcmr_pkg::VALUE_W-1:0] field_min,
  output logic signed [lcmr_pkg::VALUE_W-1:0] field_max
);
  import lcmr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  lcmr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // datapath
  lcmr_dp #(
    .MAX_CHARGES   (MAX_CHARGES),
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .op            (op),
    .charge_slot   (charge_slot),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .sample_value  (sample_value),
    .first_of_pass (first_of_pass),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .pixel_on      (pixel_on),
    .near_charge   (near_charge),
    .field_min     (field_min),
    .field_max     (field_max)
  );

endmodule

[rtl/lcmr_ctrl.sv]
// ----------------------------------------------------------------------------
// lcmr_ctrl
// Sequencer: charge scan, log jobs, band search and result strobe.
// ----------------------------------------------------------------------------
module lcmr_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [lcmr_pkg::OP_W-1:0] op,
  input  lcmr_pkg::status_t        status,
  output lcmr_pkg::cmd_t           cmd,
  output logic                     busy
);
  import lcmr_pkg::*;

  state_t state, state_next;
  job_t   job, job_next;

  // state and job registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job   <= JOB_FLOOR;
    end else begin
      state <= state_next;
      job   <= job_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    job_next   = job;
    unique case (state)
      S_IDLE: begin
        if (start && (op == OP_EXTREMA || op == OP_CONTOUR)) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (status.scan_done) begin
          job_next = JOB_FLOOR;
          if (status.op == OP_EXTREMA) state_next = S_EXT;
          else state_next = S_LOG_LOAD;
        end
      end
      S_EXT:      state_next = S_EMIT;
      S_LOG_LOAD: state_next = S_LOG_NORM;
      S_LOG_NORM: begin
        if (status.norm_done) state_next = S_LOG_SQ;
      end
      S_LOG_SQ: begin
        if (status.sq_last) state_next = S_LOG_STORE;
      end
      S_LOG_STORE: begin
        state_next = S_LOG_LOAD;
        unique case (job)
          JOB_FLOOR: job_next = status.first ? JOB_MAX : JOB_VAL;
          JOB_MAX:   job_next = JOB_MIN;
          JOB_MIN:   job_next = JOB_VAL;
          JOB_VAL:   state_next = S_BAND_INIT;
          default:   job_next = JOB_FLOOR;
        endcase
      end
      S_BAND_INIT: state_next = S_BAND;
      S_BAND: begin
        if (status.band_last) state_next = S_EMIT;
      end
      S_EMIT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd     = '0;
    cmd.job = job;
    unique case (state)
      S_IDLE:      cmd.capture    = start;
      S_SCAN:      cmd.scan_step  = 1'b1;
      S_EXT:       cmd.ext_update = 1'b1;
      S_LOG_LOAD:  cmd.log_load   = 1'b1;
      S_LOG_NORM:  cmd.log_norm   = 1'b1;
      S_LOG_SQ:    cmd.log_sq     = 1'b1;
      S_LOG_STORE: cmd.log_store  = 1'b1;
      S_BAND_INIT: cmd.band_init  = 1'b1;
      S_BAND:      cmd.band_step  = 1'b1;
      S_EMIT:      cmd.emit       = 1'b1;
      default:     cmd.capture    = 1'b0;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

[rtl/lcmr_dp.sv]
// ----------------------------------------------------------------------------
// lcmr_dp
// Datapath: config, charge store, distance check, extrema, log unit, bands.
// ----------------------------------------------------------------------------
module lcmr_dp #(
  parameter int MAX_CHARGES   = 8,
  parameter int LOG_FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lcmr_pkg::cmd_t                    cmd,
  output lcmr_pkg::status_t                 status,
  input  logic [lcmr_pkg::OP_W-1:0]         op,
  input  logic [lcmr_pkg::SLOT_W-1:0]       charge_slot,
  input  logic [lcmr_pkg::COORD_W-1:0]      x_coord,
  input  logic [lcmr_pkg::COORD_W-1:0]      y_coord,
  input  logic signed [lcmr_pkg::VALUE_W-1:0] sample_value,
  input  logic                              first_of_pass,
  input  logic                              cfg_we,
  input  logic [lcmr_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [lcmr_pkg::CFG_W-1:0]        cfg_data,
  output logic                              result_valid,
  output logic                              pixel_on,
  output logic                              near_charge,
  output logic signed [lcmr_pkg::VALUE_W-1:0] field_min,
  output logic signed [lcmr_pkg::VALUE_W-1:0] field_max
);
  import lcmr_pkg::*;

  localparam int IW  = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
  localparam int KW  = $clog2(MAX_CHARGES + 1);
  localparam int LW  = 5 + LOG_FRAC_BITS;
  localparam int AW  = LW + 10;
  localparam int SCW = $clog2(LOG_FRAC_BITS);
  localparam int PW  = 2 * COORD_W;

  // configuration registers
  logic [LINE_W-1:0]   line_count;
  logic [RADIUS_W-1:0] radius_sq;
  logic [CFG_W-1:0]    mag_floor;
  logic [COUNT_W-1:0]  charge_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= LINE_W'(15);
      radius_sq    <= RADIUS_W'(900);
      mag_floor    <= CFG_W'(1);
      charge_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_COUNT:   line_count   <= cfg_data[LINE_W-1:0];
        CFG_RADIUS_SQ:    radius_sq    <= cfg_data[RADIUS_W-1:0];
        CFG_FLOOR:        mag_floor    <= cfg_data;
        CFG_CHARGE_COUNT: charge_count <= cfg_data[COUNT_W-1:0];
        default:          line_count   <= line_count;
      endcase
    end
  end

  // charge position store, {y, x}
  logic [PW-1:0] charge_pos [MAX_CHARGES];

  always_ff @(posedge clk) begin
    if (cmd.capture && op == OP_LOAD && 32'(charge_slot) < MAX_CHARGES) begin
      charge_pos[IW'(charge_slot)] <= {y_coord, x_coord};
    end
  end

  // captured item
  logic [OP_W-1:0]           op_q;
  logic                      first_q;
  logic [COORD_W-1:0]        x_q, y_q;
  logic signed [VALUE_W-1:0] v_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op;
      first_q <= first_of_pass;
      x_q     <= x_coord;
      y_q     <= y_coord;
      v_q     <= sample_value;
    end
  end

  // charges in use, saturated
  logic [KW-1:0] used;
  assign used = (32'(charge_count) > MAX_CHARGES) ? KW'(MAX_CHARGES) : KW'(charge_count);

  // charge scan, one charge a cycle
  logic [KW-1:0]             k;
  logic                      scan_done;
  logic [PW-1:0]             pos;
  logic signed [COORD_W:0]   dx, dy;
  logic signed [2*COORD_W+1:0] dx_sq, dy_sq;
  logic [RADIUS_W:0]         dist_sq;
  logic                      near, on;

  assign scan_done = (k >= used);
  assign pos   = charge_pos[k[IW-1:0]];
  assign dx    = $signed({1'b0, x_q}) - $signed({1'b0, pos[COORD_W-1:0]});
  assign dy    = $signed({1'b0, y_q}) - $signed({1'b0, pos[PW-1:COORD_W]});
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;
  assign dist_sq = (RADIUS_W+1)'($unsigned(dx_sq)) + (RADIUS_W+1)'($unsigned(dy_sq));

  // band search registers
  logic [LINE_W-1:0]       bk;
  logic signed [AW-1:0]    a_r, t_r, d_r, bdiff, babs;
  logic                    trivial, cur_hit;

  assign bdiff   = a_r - t_r;
  assign babs    = bdiff[AW-1] ? -bdiff : bdiff;
  assign cur_hit = !trivial && (babs < d_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      k    <= '0;
      near <= 1'b0;
      on   <= 1'b0;
    end else if (cmd.scan_step && !scan_done) begin
      k <= k + KW'(1);
      if ({1'b0, dist_sq} < {2'b0, radius_sq}) near <= 1'b1;
      if (op_q == OP_CONTOUR && pos == {y_q, x_q}) on <= 1'b1;
    end else if (cmd.band_step && cur_hit) begin
      on <= 1'b1;
    end
  end

  // running extrema
  logic signed [VALUE_W-1:0] run_min, run_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min <= '0;
      run_max <= '0;
    end else if (cmd.ext_update) begin
      if (first_q) begin
        run_min <= v_q;
        run_max <= v_q;
      end else if (!near) begin
        if (v_q < run_min) run_min <= v_q;
        if (v_q > run_max) run_max <= v_q;
      end
    end
  end

  // log unit operand
  logic [VALUE_W-1:0] fl;
  logic [VALUE_W-1:0] mag;
  assign fl = (mag_floor == '0) ? VALUE_W'(1) : VALUE_W'(mag_floor);

  always_comb begin
    unique case (cmd.job)
      JOB_FLOOR: mag = fl;
      JOB_MAX:   mag = $unsigned(run_max);
      JOB_MIN:   mag = $unsigned(-run_min);
      JOB_VAL:   mag = v_q[VALUE_W-1] ? $unsigned(-v_q) : $unsigned(v_q);
      default:   mag = fl;
    endcase
  end

  // log unit: normalize a bit a cycle, then one squaring a cycle
  logic [VALUE_W-1:0]       lm;
  logic [4:0]               le;
  logic [LOG_FRAC_BITS-1:0] lfrac;
  logic [SCW-1:0]           sq_cnt;
  logic [2*VALUE_W-1:0]     prod;
  logic [VALUE_W:0]         sq;
  logic [LW-1:0]            lg;

  assign prod = lm * lm;
  assign sq   = prod[2*VALUE_W-1:VALUE_W-1];
  assign lg   = (lm == '0) ? '0 : {le, lfrac};

  always_ff @(posedge clk) begin
    if (cmd.log_load) begin
      lm     <= mag;
      le     <= 5'd31;
      lfrac  <= '0;
      sq_cnt <= '0;
    end else if (cmd.log_norm && !(lm[VALUE_W-1] || lm == '0)) begin
      lm <= {lm[VALUE_W-2:0], 1'b0};
      le <= le - 5'd1;
    end else if (cmd.log_sq) begin
      sq_cnt <= sq_cnt + SCW'(1);
      if (sq[VALUE_W]) begin
        lfrac <= {lfrac[LOG_FRAC_BITS-2:0], 1'b1};
        lm    <= sq[VALUE_W:1];
      end else begin
        lfrac <= {lfrac[LOG_FRAC_BITS-2:0], 1'b0};
        lm    <= sq[VALUE_W-1:0];
      end
    end
  end

  // log results and latched level scales
  logic [LW-1:0] lg_floor, lg_max, lg_val;
  logic [LW-1:0] pos_scale, neg_scale;
  logic          max_active, min_active;

  assign max_active = $signed({run_max[VALUE_W-1], run_max}) > $signed({1'b0, fl});
  assign min_active = $signed({run_min[VALUE_W-1], run_min}) < -$signed({1'b0, fl});

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_scale <= '0;
      neg_scale <= '0;
    end else if (cmd.log_store) begin
      unique case (cmd.job)
        JOB_FLOOR: lg_floor <= lg;
        JOB_MAX:   lg_max   <= lg;
        JOB_MIN: begin
          pos_scale <= max_active ? lg_max - lg_floor : '0;
          neg_scale <= min_active ? lg - lg_floor : '0;
        end
        JOB_VAL:   lg_val   <= lg;
        default:   lg_val   <= lg_val;
      endcase
    end
  end

  // band setup and search, one level a cycle
  logic [LW-1:0]        span;
  logic signed [LW:0]   ldiff;
  logic [LINE_W-1:0]    nm1;

  assign span  = (v_q > 0) ? pos_scale : ((v_q < 0) ? neg_scale : '0);
  assign ldiff = $signed({1'b0, lg_val}) - $signed({1'b0, lg_floor});
  assign nm1   = line_count - LINE_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.band_init) begin
      a_r     <= (AW'(ldiff) * $signed({{(AW-LINE_W){1'b0}}, nm1})) <<< 2;
      d_r     <= $signed({{(AW-LW){1'b0}}, span});
      t_r     <= '0;
      bk      <= '0;
      trivial <= (line_count <= LINE_W'(1)) || (span == '0);
    end else if (cmd.band_step) begin
      t_r <= t_r + (d_r <<< 2);
      bk  <= bk + LINE_W'(1);
    end
  end

  // status back to the sequencer
  assign status.op        = op_q;
  assign status.first     = first_q;
  assign status.scan_done = scan_done;
  assign status.norm_done = lm[VALUE_W-1] || lm == '0;
  assign status.sq_last   = (32'(sq_cnt) == LOG_FRAC_BITS - 1);
  assign status.band_last = trivial || cur_hit || (bk == nm1);

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= cmd.emit;
  end

  assign pixel_on    = on;
  assign near_charge = near;
  assign field_min   = run_min;
  assign field_max   = run_max;

endmodule

[dv/log_contour_mask_render_tb.sv]
// ----------------------------------------------------------------------------
// log_contour_mask_render_tb
// Self-checking bench for the contour mask renderer: charge loads, extrema
// passes and contour passes are driven through the start/busy port, and every
// result strobe is checked against a cycle-free model of the block.
// ----------------------------------------------------------------------------
module log_contour_mask_render_tb;
  import lcmr_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int NUM_CHARGES = 8;
  localparam int FRAC_BITS = 8;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [SLOT_W-1:0] slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic signed [VALUE_W-1:0] value;
    logic first;
  } sample_item_t;

  typedef struct {
    logic on;
    logic near;
    logic signed [VALUE_W-1:0] fmin;
    logic signed [VALUE_W-1:0] fmax;
  } pixel_result_t;

  // mask scoreboard: shadow state of the renderer and pending pixel results
  class mask_scoreboard;
    logic [17:0] charge_pos[NUM_CHARGES];
    logic signed [VALUE_W-1:0] run_min, run_max;
    logic [31:0] pos_span, neg_span;
    logic [LINE_W-1:0] lines;
    logic [RADIUS_W-1:0] radius_sq;
    logic [CFG_W-1:0] mag_floor;
    logic [COUNT_W-1:0] num_used;
    pixel_result_t pending_q[$];
    int errors;

    function new();
      foreach (charge_pos[k]) charge_pos[k] = '0;
      run_min = '0; run_max = '0; pos_span = '0; neg_span = '0;
      lines = LINE_W'(15); radius_sq = RADIUS_W'(900); mag_floor = CFG_W'(1);
      num_used = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_LINE_COUNT: lines = data[LINE_W-1:0];
        CFG_RADIUS_SQ: radius_sq = data[RADIUS_W-1:0];
        CFG_FLOOR: mag_floor = data;
        CFG_CHARGE_COUNT: num_used = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // floor(log2(v) * 2^FRAC_BITS), fraction by repeated squaring
    function logic [31:0] log2_fix(logic [31:0] v);
      int e;
      logic [31:0] frac;
      longint unsigned m;
      if (v == 0) return 0;
      e = 31;
      while (v[e] == 1'b0) e--;
      m = longint'(v) << (31 - e);
      frac = 0;
      for (int i = 0; i < FRAC_BITS; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m >= 64'h1_0000_0000) begin
          frac[0] = 1'b1;
          m = m >> 1;
        end
      end
      return (32'(e) << FRAC_BITS) | frac;
    endfunction

    function logic [31:0] floor_val();
      return (mag_floor == 0) ? 32'd1 : 32'(mag_floor);
    endfunction

    function int used();
      return (num_used > NUM_CHARGES) ? NUM_CHARGES : int'(num_used);
    endfunction

    function logic near_any(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      longint dx, dy;
      for (int k = 0; k < used(); k++) begin
        dx = longint'(x) - longint'(charge_pos[k][8:0]);
        dy = longint'(y) - longint'(charge_pos[k][17:9]);
        if (dx * dx + dy * dy < longint'(radius_sq)) return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic on_charge(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      for (int k = 0; k < used(); k++)
        if (charge_pos[k] == {y, x}) return 1'b1;
      return 1'b0;
    endfunction

    // band test against the log-spaced levels of one sign
    function logic in_band(logic [31:0] mag, logic [31:0] span);
      longint n, a, d, diff;
      if (lines <= 1 || span == 0) return 1'b0;
      n = longint'(lines);
      d = longint'(span);
      a = 4 * (n - 1) * (longint'(log2_fix(mag)) - longint'(log2_fix(floor_val())));
      for (longint k = 0; k < n; k++) begin
        diff = a - 4 * k * d;
        if (diff < 0) diff = -diff;
        if (diff < d) return 1'b1;
      end
      return 1'b0;
    endfunction

    // accepted item: update state and queue its result, if any
    function void note_item(sample_item_t it);
      pixel_result_t r;
      longint v, fl, mx, mn;
      logic [31:0] lf;
      if (it.op == OP_LOAD) begin
        charge_pos[it.slot] = {it.y, it.x};
        return;
      end
      if (it.op == OP_UNUSED) return;
      v = longint'(it.value);
      r.on = 1'b0;
      r.near = near_any(it.x, it.y);
      if (it.op == OP_EXTREMA) begin
        if (it.first) begin
          run_min = it.value; run_max = it.value;
        end else if (!r.near) begin
          if (it.value < run_min) run_min = it.value;
          if (it.value > run_max) run_max = it.value;
        end
      end else begin
        if (it.first) begin
          fl = longint'(floor_val());
          mx = longint'(run_max);
          mn = longint'(run_min);
          lf = log2_fix(32'(fl));
          pos_span = (mx > fl) ? log2_fix(32'(mx)) - lf : 32'd0;
          neg_span = (mn < -fl) ? log2_fix(32'(-mn)) - lf : 32'd0;
        end
        if (v > 0) r.on = in_band(32'(v), pos_span);
        else if (v < 0) r.on = in_band(32'(-v), neg_span);
        if (on_charge(it.x, it.y)) r.on = 1'b1;
      end
      r.fmin = run_min;
      r.fmax = run_max;
      pending_q.push_back(r);
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endfunction

    function void check_result(pixel_result_t got);
      pixel_result_t exp_r;
      if (pending_q.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.on !== exp_r.on)
        report($sformatf("pixel_on got %b want %b", got.on, exp_r.on));
      if (got.near !== exp_r.near)
        report($sformatf("near_charge got %b want %b", got.near, exp_r.near));
      if (got.fmin !== exp_r.fmin)
        report($sformatf("field_min got %0d want %0d", got.fmin, exp_r.fmin));
      if (got.fmax !== exp_r.fmax)
        report($sformatf("field_max got %0d want %0d", got.fmax, exp_r.fmax));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0] op = OP_LOAD;
  logic [SLOT_W-1:0] charge_slot = '0;
  logic [COORD_W-1:0] x_coord = '0;
  logic [COORD_W-1:0] y_coord = '0;
  logic signed [VALUE_W-1:0] sample_value = '0;
  logic first_of_pass = 1'b0;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic result_valid;
  logic pixel_on;
  logic near_charge;
  logic signed [VALUE_W-1:0] field_min;
  logic signed [VALUE_W-1:0] field_max;

  mask_scoreboard sb = new();
  int idle_pct = 0;
  int stall_cnt = 0;
  logic [17:0] charge_pos_tb[NUM_CHARGES];

  log_contour_mask_render uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .charge_slot(charge_slot), .x_coord(x_coord), .y_coord(y_coord),
    .sample_value(sample_value), .first_of_pass(first_of_pass),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .pixel_on(pixel_on), .near_charge(near_charge),
    .field_min(field_min), .field_max(field_max)
  );

  always #6 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    pixel_result_t r;
    if (!rst && result_valid) begin
      r.on = pixel_on; r.near = near_charge; r.fmin = field_min; r.fmax = field_max;
      sb.check_result(r);
    end
  end

  // watchdog on cycles with no item and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("log_contour_mask_render test failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // drive one item and hold it until accepted
  task automatic send_item(logic [OP_W-1:0] o, logic [SLOT_W-1:0] s,
                           logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic signed [VALUE_W-1:0] v, logic f);
    sample_item_t it;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    op = o; charge_slot = s; x_coord = x; y_coord = y; sample_value = v;
    first_of_pass = f; start = 1'b1;
    do @(posedge clk); while (busy);
    it.op = o; it.slot = s; it.x = x; it.y = y; it.value = v; it.first = f;
    sb.note_item(it);
    if (o == OP_LOAD) charge_pos_tb[s] = {y, x};
  endtask

  // let the block go idle with nothing pending
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // value near a power of two, often on a level; sometimes random or small
  function automatic logic signed [VALUE_W-1:0] rand_value();
    logic [31:0] mag;
    case ($urandom_range(4))
      0: return $urandom;
      1: return $signed(32'($urandom_range(40))) - 20;
      default: begin
        mag = (32'd1 << $urandom_range(30)) + $urandom_range(3);
        if ($urandom_range(2) == 0) mag = mag + (mag >> $urandom_range(1, 4));
        mag = mag & 32'h7fff_ffff;
        return $urandom_range(1) ? $signed(mag) : -$signed(mag);
      end
    endcase
  endfunction

  // pixel: random, or next to / on a loaded charge
  task automatic rand_pixel(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
    logic [17:0] p;
    if ($urandom_range(2) == 0) begin
      p = charge_pos_tb[$urandom_range(NUM_CHARGES - 1)];
      x = p[8:0] + ($urandom_range(3) == 0 ? 9'd0 : 9'($urandom_range(60)) - 9'd30);
      y = p[17:9] + ($urandom_range(3) == 0 ? 9'd0 : 9'($urandom_range(60)) - 9'd30);
    end else begin
      x = COORD_W'($urandom); y = COORD_W'($urandom);
    end
  endtask

  task automatic random_config();
    int pick;
    pick = $urandom_range(3);
    write_cfg(CFG_LINE_COUNT,
              CFG_W'(pick == 0 ? 1 : pick == 1 ? 64 : $urandom_range(2, 64)));
    pick = $urandom_range(3);
    write_cfg(CFG_RADIUS_SQ,
              CFG_W'(pick == 0 ? 0 : pick == 1 ? 20'hfffff : $urandom_range(4000)));
    pick = $urandom_range(4);
    write_cfg(CFG_FLOOR, CFG_W'(pick == 0 ? 1 : pick == 1 ? 31'h7fff_ffff :
              pick == 2 ? 0 : 31'(1) << $urandom_range(12)));
    write_cfg(CFG_CHARGE_COUNT, CFG_W'($urandom_range(15)));
  endtask

  // one extrema pass followed by one contour pass
  task automatic render_frame(int n);
    logic [COORD_W-1:0] x, y;
    for (int i = 0; i < n; i++) begin
      rand_pixel(x, y);
      send_item(OP_EXTREMA, SLOT_W'($urandom), x, y, rand_value(), i == 0);
    end
    for (int i = 0; i < n; i++) begin
      rand_pixel(x, y);
      send_item(OP_CONTOUR, SLOT_W'($urandom), x, y, rand_value(), i == 0);
    end
  endtask

  initial begin
    int phase_pct[4] = '{0, 84, 0, 25};
    logic [COORD_W-1:0] x, y;
    int sent;
    int n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: every slot loaded, extremes of coordinates
    for (int s = 0; s < NUM_CHARGES; s++)
      send_item(OP_LOAD, SLOT_W'(s), s == 0 ? 9'd0 : s == 1 ? 9'd511 : 9'($urandom),
                s == 0 ? 9'd0 : s == 1 ? 9'd511 : 9'($urandom), $urandom, 1'($urandom));
    send_item(OP_UNUSED, 3'd7, 9'd511, 9'd511, 32'hffff_ffff, 1'b1);
    // contour before any seed uses zero scales
    send_item(OP_CONTOUR, 3'd0, 9'd5, 9'd5, 32'sd100, 1'b0);
    send_item(OP_EXTREMA, 3'd0, 9'd100, 9'd100, 32'sh7fff_ffff, 1'b1);
    send_item(OP_EXTREMA, 3'd0, 9'd200, 9'd200, 32'sh8000_0000, 1'b0);
    send_item(OP_EXTREMA, 3'd0, 9'd300, 9'd300, 32'sd0, 1'b0);
    send_item(OP_CONTOUR, 3'd0, 9'd10, 9'd10, 32'sd1 << 16, 1'b1);
    send_item(OP_CONTOUR, 3'd0, 9'd11, 9'd10, -(32'sd1 << 24), 1'b0);
    send_item(OP_CONTOUR, 3'd0, 9'd12, 9'd10, 32'sd0, 1'b0);
    send_item(OP_CONTOUR, 3'd0, 9'd13, 9'd10, 32'sh8000_0000, 1'b0);
    drain();
    // all charges in use (count saturates), charge pixel and near pixel
    write_cfg(CFG_CHARGE_COUNT, 31'd15);
    write_cfg(CFG_FLOOR, 31'd0);
    write_cfg(CFG_LINE_COUNT, 31'd1);
    send_item(OP_EXTREMA, 3'd0, 9'd0, 9'd0, 32'sd5000, 1'b1);
    send_item(OP_EXTREMA, 3'd0, 9'd3, 9'd3, 32'sd9000000, 1'b0);
    send_item(OP_CONTOUR, 3'd0, 9'd0, 9'd0, 32'sd7, 1'b1);
    send_item(OP_CONTOUR, 3'd0, 9'd200, 9'd40, 32'sd5000, 1'b0);
    drain();
    write_cfg(CFG_LINE_COUNT, 31'd0);
    write_cfg(CFG_RADIUS_SQ, 31'h000f_ffff);
    send_item(OP_EXTREMA, 3'd0, 9'd50, 9'd50, -32'sd70000, 1'b1);
    send_item(OP_CONTOUR, 3'd0, 9'd511, 9'd511, -32'sd700, 1'b1);
    drain();

    // random frames, config and idling change per phase
    sent = 0;
    for (int ph = 0; sent < 600; ph++) begin
      idle_pct = phase_pct[ph % 4];
      random_config();
      if ($urandom_range(1)) begin
        for (int s = 0; s < NUM_CHARGES; s++) begin
          x = COORD_W'($urandom); y = COORD_W'($urandom);
          send_item(OP_LOAD, SLOT_W'(s), x, y, $urandom, 1'($urandom));
        end
        send_item(OP_UNUSED, SLOT_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                  $urandom, 1'($urandom));
        sent += NUM_CHARGES + 1;
      end
      for (int f = 0; f < 6; f++) begin
        n = $urandom_range(2, 14);
        render_frame(n);
        sent += 2 * n;
        if ($urandom_range(5) == 0) begin
          rand_pixel(x, y);
          send_item($urandom_range(1) ? OP_EXTREMA : OP_CONTOUR, SLOT_W'($urandom),
                    x, y, rand_value(), 1'($urandom));
          sent += 1;
        end
      end
      drain();
    end

    @(negedge clk);
    start = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (sb.errors == 0) begin
      $display("log_contour_mask_render test passed");
    end else begin
      $display("log_contour_mask_render test failed");
    end
    $finish;
  end

endmodule

[log_contour_mask_render.f]
rtl/lcmr_pkg.sv
rtl/lcmr_ctrl.sv
rtl/lcmr_dp.sv
rtl/log_contour_mask_render.sv
dv/log_contour_mask_render_tb.sv
